@@ rtl/bmcls_pkg.sv @@
// ----------------------------------------------------------------------------
// bmcls_pkg: shared types and constants of the bank mapper
// Operation codes, register window addresses, bank fields and clamp helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package bmcls_pkg;

	// Operation carried by one item.
	typedef enum logic [1:0] {
		OP_REG_WRITE = 2'd0,
		OP_CHR_FETCH = 2'd1,
		OP_PRG_FETCH = 2'd2
	} op_t;

	// Index of a configuration register on the write port.
	typedef enum logic [1:0] {
		CFG_PRG_BANK_MAX    = 2'd0,
		CFG_CHR_2K_BANK_MAX = 2'd1,
		CFG_CHR_1K_BANK_MAX = 2'd2
	} cfg_idx_t;

	// CPU register window.
	localparam logic [15:0] REG_WIN_LO = 16'h7EF0;
	localparam logic [15:0] REG_WIN_HI = 16'h7EFF;

	// Low address nibble of the registers inside the window.
	localparam logic [3:0] REG_CHR2K_FIRST = 4'h0;
	localparam logic [3:0] REG_CHR2K_LAST  = 4'h1;
	localparam logic [3:0] REG_CHR1K_FIRST = 4'h2;
	localparam logic [3:0] REG_CHR1K_LAST  = 4'h5;
	localparam logic [3:0] REG_CONTROL     = 4'h6;
	localparam logic [3:0] REG_PRG_FIRST   = 4'hA;
	localparam logic [3:0] REG_PRG_LAST    = 4'hC;

	// Fixed top program slot.
	localparam logic [1:0] PRG_FIXED_SLOT = 2'd3;

	// Reset values of the configuration registers.
	localparam logic [7:0] PRG_BANK_MAX_RST    = 8'hFF;
	localparam logic [6:0] CHR_2K_BANK_MAX_RST = 7'h7F;
	localparam logic [7:0] CHR_1K_BANK_MAX_RST = 8'hFF;

	typedef logic [6:0] chr2k_bank_t;
	typedef logic [7:0] chr1k_bank_t;
	typedef logic [5:0] prg_bank_t;
	typedef logic [20:0] rom_addr_t;

	// A bank number above the maximum is masked with the maximum.
	function automatic chr2k_bank_t clamp_chr2k(input chr2k_bank_t v, input chr2k_bank_t mx);
		return (v > mx) ? (v & mx) : v;
	endfunction

	function automatic chr1k_bank_t clamp_chr1k(input chr1k_bank_t v, input chr1k_bank_t mx);
		return (v > mx) ? (v & mx) : v;
	endfunction

	function automatic prg_bank_t clamp_prg(input prg_bank_t v, input logic [7:0] mx);
		return ({2'b00, v} > mx) ? (v & mx[5:0]) : v;
	endfunction

endpackage

`default_nettype wire

@@ rtl/bank_mapper_with_chr_layout_swap_unit.sv @@
// ----------------------------------------------------------------------------
// bank_mapper_with_chr_layout_swap_unit: cartridge bank mapper with CHR swap
// Path: an accepted item passes through the input register, then the result
// register, from which it can be taken (input register, then result register).
// Throughput: one item per cycle while the result channel does not stall, set
// by the single translation pass between the two registers; an empty input stage may fill alone.
// Reset (arst_n low, asynchronous): bank registers and layout control clear to
// zero, the bank maximum registers return to all ones, both stages empty.
// ----------------------------------------------------------------------------
`default_nettype none

// The block translates pattern (PPU) and program (CPU) fetch addresses into
// ROM byte addresses and takes CPU register writes in the 0x7EF0-0x7EFF
// window. Every item yields exactly one result item. Register writes update
// the bank state at the moment the item leaves the input register, so the
// next item behind it already sees the new banks.
module bank_mapper_with_chr_layout_swap_unit (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// Input channel.
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [1:0]            op,
	input  wire logic [15:0]           address,
	input  wire logic [7:0]            write_value,
	// Result channel.
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output bmcls_pkg::rom_addr_t       mapped_address,
	output logic                       mapped_valid,
	output logic                       mirror_vertical,
	// Configuration write port.
	input  wire logic                  cfg_we,
	input  wire logic [1:0]            cfg_index,
	input  wire logic [7:0]            cfg_wdata
);

	import bmcls_pkg::*;

	// Configuration registers.
	logic [7:0]  prg_max_q;
	chr2k_bank_t chr2k_max_q;
	chr1k_bank_t chr1k_max_q;

	// Mapper state.
	chr2k_bank_t chr2k_q [2];
	chr1k_bank_t chr1k_q [4];
	prg_bank_t   prg_q [3];
	logic [1:0]  layout_q;

	// Input stage.
	logic        valid_s1;
	logic [1:0]  op_s1;
	logic [15:0] addr_s1;
	logic [7:0]  wval_s1;

	// Result stage.
	logic        out_valid_q;
	rom_addr_t   mapped_q;
	logic        hit_q;
	logic        mirror_q;

	// The input stage drains whenever the result register is empty or its
	// item is being taken this cycle, and takes a new item whenever it is empty.
	logic advance;
	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;

	// Translation and write decode of the item in the input stage.
	logic       in_window;
	logic [3:0] reg_nib;
	logic       wr_chr2k, wr_chr1k, wr_ctrl, wr_prg;
	logic [1:0] layout_nxt;
	logic [2:0] chr_slot;
	logic [1:0] prg_slot;
	rom_addr_t  mapped_d;
	logic       hit_d;

	assign in_window = (addr_s1 >= REG_WIN_LO) && (addr_s1 <= REG_WIN_HI);
	assign reg_nib   = addr_s1[3:0];

	always_comb begin
		wr_chr2k = 1'b0;
		wr_chr1k = 1'b0;
		wr_ctrl  = 1'b0;
		wr_prg   = 1'b0;
		if (valid_s1 && advance && (op_s1 == OP_REG_WRITE) && in_window) begin
			case (reg_nib) inside
				[REG_CHR2K_FIRST:REG_CHR2K_LAST]: wr_chr2k = 1'b1;
				[REG_CHR1K_FIRST:REG_CHR1K_LAST]: wr_chr1k = 1'b1;
				REG_CONTROL:                      wr_ctrl  = 1'b1;
				[REG_PRG_FIRST:REG_PRG_LAST]:     wr_prg   = 1'b1;
				default: begin
					// Unused register addresses are ignored.
				end
			endcase
		end
	end

	// Mirroring in the result reflects a control write carried by the same item.
	assign layout_nxt = wr_ctrl ? wval_s1[1:0] : layout_q;

	// With the swap bit set, the 2K half and the 1K half trade places.
	assign chr_slot = addr_s1[12:10] ^ {layout_q[1], 2'b00};
	assign prg_slot = addr_s1[14:13];

	always_comb begin
		mapped_d = '0;
		hit_d    = 1'b0;
		case (op_s1)
			OP_CHR_FETCH: begin
				if (addr_s1[15:13] == 3'b000) begin
					hit_d = 1'b1;
					if (!chr_slot[2]) begin
						mapped_d = {3'b000, chr2k_q[chr_slot[1]], addr_s1[10:0]};
					end else begin
						mapped_d = {3'b000, chr1k_q[chr_slot[1:0]], addr_s1[9:0]};
					end
				end
			end
			OP_PRG_FETCH: begin
				if (addr_s1[15]) begin
					hit_d = 1'b1;
					// The top slot is fixed to the last program bank.
					if (prg_slot == PRG_FIXED_SLOT) begin
						mapped_d = {prg_max_q, addr_s1[12:0]};
					end else begin
						mapped_d = {2'b00, prg_q[prg_slot], addr_s1[12:0]};
					end
				end
			end
			default: begin
				// Register writes and the unused code return an empty result.
			end
		endcase
	end

	// Configuration registers; an index beyond the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_max_q   <= PRG_BANK_MAX_RST;
			chr2k_max_q <= CHR_2K_BANK_MAX_RST;
			chr1k_max_q <= CHR_1K_BANK_MAX_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PRG_BANK_MAX:    prg_max_q   <= cfg_wdata;
				CFG_CHR_2K_BANK_MAX: chr2k_max_q <= cfg_wdata[6:0];
				CFG_CHR_1K_BANK_MAX: chr1k_max_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// Bank registers, loaded by CPU writes into the register window.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chr2k_q  <= '{default: '0};
			chr1k_q  <= '{default: '0};
			prg_q    <= '{default: '0};
			layout_q <= '0;
		end else begin
			if (wr_chr2k) begin
				chr2k_q[reg_nib[0]] <= clamp_chr2k(wval_s1[7:1], chr2k_max_q);
			end
			if (wr_chr1k) begin
				// Nibbles 2..5 map to entries 0..3.
				chr1k_q[2'(reg_nib - REG_CHR1K_FIRST)] <= clamp_chr1k(wval_s1, chr1k_max_q);
			end
			if (wr_prg) begin
				prg_q[2'(reg_nib - REG_PRG_FIRST)] <= clamp_prg(wval_s1[7:2], prg_max_q);
			end
			layout_q <= layout_nxt;
		end
	end

	// Input stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Input stage payload.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1   <= op;
			addr_s1 <= address;
			wval_s1 <= write_value;
		end
	end

	// Result stage control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	// Result stage payload.
	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			mapped_q <= mapped_d;
			hit_q    <= hit_d;
			mirror_q <= layout_nxt[0];
		end
	end

	assign out_valid       = out_valid_q;
	assign mapped_address  = mapped_q;
	assign mapped_valid    = hit_q;
	assign mirror_vertical = mirror_q;

endmodule

`default_nettype wire

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for bank_mapper_with_chr_layout_swap_unit
// Register writes, pattern fetches and program fetches go in as items. Each
// item's result is predicted from a shadow of the bank state and compared
// field by field. The run covers several bank limit settings and uses random
// gaps on both channels.
// ----------------------------------------------------------------------------
module tb;

	import bmcls_pkg::*;

	// The op code left unused by the block, and a configuration index past
	// the last register. Both must leave the state alone.
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam logic [1:0] CFG_NONE  = 2'd3;

	// Random traffic: one block of items per bank limit setting.
	localparam int PHASES          = 6;
	localparam int ITEMS_PER_PHASE = 175;

	// One item on the input channel. The kind is a raw code so that the
	// unused op can be sent as well.
	typedef struct {
		logic [1:0]  kind;
		logic [15:0] addr;
		logic [7:0]  value;
	} bus_item_t;

	// One result item as the bench expects it.
	typedef struct packed {
		rom_addr_t rom_addr;
		logic      hit;
		logic      mirror_v;
	} mapping_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  op = 2'd0;
	logic [15:0] address = 16'd0;
	logic [7:0]  write_value = 8'd0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	rom_addr_t   mapped_address;
	logic        mapped_valid;
	logic        mirror_vertical;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = 2'd0;
	logic [7:0]  cfg_wdata = 8'd0;

	bank_mapper_with_chr_layout_swap_unit DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.op              (op),
		.address         (address),
		.write_value     (write_value),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.mapped_address  (mapped_address),
		.mapped_valid    (mapped_valid),
		.mirror_vertical (mirror_vertical),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Shadow of the mapper state. The bank limits are only changed while the
	// block is idle, so the shadow can follow them at once.
	// ------------------------------------------------------------------------
	logic [7:0] chr_banks [0:5];
	logic [1:0] layout_ctl;
	logic [5:0] prg_banks [0:2];
	logic [7:0] max_prg   = PRG_BANK_MAX_RST;
	logic [6:0] max_chr2k = CHR_2K_BANK_MAX_RST;
	logic [7:0] max_chr1k = CHR_1K_BANK_MAX_RST;

	initial begin
		for (int i = 0; i < 6; i++)
			chr_banks[i] = 8'd0;
		for (int i = 0; i < 3; i++)
			prg_banks[i] = 6'd0;
		layout_ctl = 2'd0;
	end

	// Applies one accepted item to the shadow state and returns the result
	// the block must produce for it. Register writes take effect before the
	// result is formed, so the mirroring bit of a control write already shows
	// the new value.
	function automatic mapping_t translate_item(input logic [1:0] kind,
			input logic [15:0] a, input logic [7:0] v);
		mapping_t   r;
		logic [3:0] n;
		logic [2:0] slot;
		logic [6:0] b2;
		logic [7:0] b8;
		logic [2:0] ci;
		logic [1:0] pi;

		r = '0;
		case (kind)
			OP_REG_WRITE: begin
				if (a >= REG_WIN_LO && a <= REG_WIN_HI) begin
					n = a[3:0];
					if (n <= REG_CHR2K_LAST) begin
						// 2K banks count in 2K units, hence the shift.
						b2 = v[7:1];
						chr_banks[n[2:0]] = {1'b0, (b2 > max_chr2k) ? (b2 & max_chr2k) : b2};
					end else if (n <= REG_CHR1K_LAST) begin
						chr_banks[n[2:0]] = (v > max_chr1k) ? (v & max_chr1k) : v;
					end else if (n == REG_CONTROL) begin
						layout_ctl = v[1:0];
					end else if (n >= REG_PRG_FIRST && n <= REG_PRG_LAST) begin
						// Program banks are written in 8K units and kept to six bits.
						b8 = {2'b00, v[7:2]};
						b8 = (b8 > max_prg) ? (b8 & max_prg) : b8;
						pi = 2'(n - REG_PRG_FIRST);
						prg_banks[pi] = b8[5:0];
					end
				end
			end
			OP_CHR_FETCH: begin
				if (a < 16'h2000) begin
					// The swap bit trades the 2K half with the 1K half.
					slot = a[12:10];
					if (layout_ctl[1])
						slot[2] = ~slot[2];
					if (!slot[2]) begin
						r.rom_addr = {2'b00, chr_banks[{2'b00, slot[1]}], a[10:0]};
					end else begin
						ci = {1'b0, slot[1:0]} + 3'd2;
						r.rom_addr = {3'b000, chr_banks[ci], a[9:0]};
					end
					r.hit = 1'b1;
				end
			end
			OP_PRG_FETCH: begin
				if (a[15]) begin
					// The top slot always maps to the last bank, the limit itself.
					if (a[14:13] == PRG_FIXED_SLOT)
						b8 = max_prg;
					else
						b8 = {2'b00, prg_banks[a[14:13]]};
					r.rom_addr = {b8, a[12:0]};
					r.hit = 1'b1;
				end
			end
			default: ;
		endcase
		r.mirror_v = layout_ctl[0];
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus queue, expectation queue and run statistics.
	// ------------------------------------------------------------------------
	bus_item_t   pending_items[$];
	mapping_t    expected_mappings[$];
	bus_item_t   next_item;
	mapping_t    want;
	logic        sender_hold = 1'b0;
	logic [3:0]  send_wait;
	logic        send_burst;
	int unsigned recv_wait;
	int unsigned recv_next;
	logic        recv_burst;
	int          error_count = 0;
	int          items_sent = 0;
	int          reg_writes_sent = 0;
	int          results_seen = 0;
	int          hits_seen = 0;

	// ------------------------------------------------------------------------
	// Driver. An item is predicted at the edge where it is accepted. After
	// each item the sender may pause before offering the next, except during
	// bursts, where items follow back to back. Bursts switch on and off at
	// random so that gaps land on every phase of the traffic.
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			op <= OP_REG_WRITE;
			address <= '0;
			write_value <= '0;
			send_wait <= '0;
			send_burst <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				expected_mappings.push_back(translate_item(op, address, write_value));
				items_sent++;
				if (op == OP_REG_WRITE)
					reg_writes_sent++;
			end
			// Valid holds with its payload until the item is taken.
			if (!in_valid || in_ready) begin
				if (send_wait != 0) begin
					send_wait <= send_wait - 1'b1;
					in_valid <= 1'b0;
				end else if (sender_hold || pending_items.size() == 0) begin
					in_valid <= 1'b0;
				end else begin
					next_item = pending_items.pop_front();
					op <= next_item.kind;
					address <= next_item.addr;
					write_value <= next_item.value;
					in_valid <= 1'b1;
					if ($urandom_range(0, 31) == 0)
						send_burst <= !send_burst;
					send_wait <= send_burst ? 4'd0 : 4'($urandom_range(0, 13));
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor. Every accepted result is matched against the oldest
	// expectation. After each result the receiver may stall before it takes
	// the next, again with random bursts of no stalling at all.
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_wait <= 0;
			recv_burst <= 1'b0;
		end else begin
			recv_next = recv_wait;
			if (out_valid && out_ready) begin
				results_seen++;
				if (expected_mappings.size() == 0) begin
					error_count++;
					$display("%0t: result with no item outstanding: address %h valid %b mirror %b",
						$time, mapped_address, mapped_valid, mirror_vertical);
				end else begin
					want = expected_mappings.pop_front();
					if (want.hit)
						hits_seen++;
					if (mapped_address !== want.rom_addr) begin
						error_count++;
						$display("%0t: mapped_address expected %h, got %h",
							$time, want.rom_addr, mapped_address);
					end
					if (mapped_valid !== want.hit) begin
						error_count++;
						$display("%0t: mapped_valid expected %b, got %b",
							$time, want.hit, mapped_valid);
					end
					if (mirror_vertical !== want.mirror_v) begin
						error_count++;
						$display("%0t: mirror_vertical expected %b, got %b",
							$time, want.mirror_v, mirror_vertical);
					end
				end
				if ($urandom_range(0, 31) == 0)
					recv_burst <= !recv_burst;
				recv_next = recv_burst ? 0 : $urandom_range(0, 13);
			end
			if (recv_next != 0) begin
				out_ready <= 1'b0;
				recv_wait <= recv_next - 1;
			end else begin
				out_ready <= 1'b1;
				recv_wait <= 0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers.
	// ------------------------------------------------------------------------
	task automatic push_item(input logic [1:0] kind, input logic [15:0] a,
			input logic [7:0] v);
		bus_item_t it;
		it.kind = kind;
		it.addr = a;
		it.value = v;
		pending_items.push_back(it);
	endtask

	// Drives one configuration write and mirrors it in the shadow. The caller
	// lowers the write enable after the last write of a group.
	task automatic set_limit(input logic [1:0] idx, input logic [7:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		case (idx)
			CFG_PRG_BANK_MAX:    max_prg = data;
			CFG_CHR_2K_BANK_MAX: max_chr2k = data[6:0];
			CFG_CHR_1K_BANK_MAX: max_chr1k = data;
			default: ;
		endcase
	endtask

	// Waits until the sender has nothing left and every result is back, then
	// lets the two-stage pipeline settle before it returns. The check
	// is made at the falling edge, where the driver's updates have settled.
	task automatic wait_until_idle();
		while (pending_items.size() != 0 || in_valid || expected_mappings.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Random traffic. Most register writes land in the register window and
	// most fetches in the mapped windows, so that the bank state keeps moving
	// and the lookups exercise it. The rest go anywhere in the address space.
	function automatic bus_item_t random_item();
		bus_item_t   it;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		it.value = 8'($urandom_range(0, 255));
		it.addr = 16'($urandom_range(0, 16'hFFFF));
		if (pick < 30) begin
			it.kind = OP_REG_WRITE;
			if (pick < 26)
				it.addr[15:4] = REG_WIN_LO[15:4];
		end else if (pick < 65) begin
			it.kind = OP_CHR_FETCH;
			if (pick < 60)
				it.addr[15:13] = 3'b000;
		end else if (pick < 95) begin
			it.kind = OP_PRG_FETCH;
			if (pick < 90)
				it.addr[15] = 1'b1;
		end else begin
			it.kind = OP_UNUSED;
		end
		return it;
	endfunction

	// ------------------------------------------------------------------------
	// Test sequence.
	// ------------------------------------------------------------------------
	logic [7:0] lim_prg;
	logic [7:0] lim_chr2k;
	logic [7:0] lim_chr1k;

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed part, run with the limits left at their reset values.
		// Lookups straight after reset see all banks at zero, and the fixed
		// top slot lands on the last bank of the largest ROM.
		push_item(OP_CHR_FETCH, 16'h0000, 8'hFF);
		push_item(OP_PRG_FETCH, 16'hFFFF, 8'h00);
		push_item(OP_PRG_FETCH, 16'h7FFF, 8'h00);	// just below program space
		push_item(OP_CHR_FETCH, 16'h2000, 8'h00);	// just past pattern space
		// Load every kind of bank register, some with extreme values.
		push_item(OP_REG_WRITE, 16'h7EF0, 8'hFF);
		push_item(OP_REG_WRITE, 16'h7EF1, 8'h02);
		push_item(OP_REG_WRITE, 16'h7EF2, 8'hFF);
		push_item(OP_REG_WRITE, 16'h7EF5, 8'h80);
		push_item(OP_REG_WRITE, 16'h7EFA, 8'hFF);
		push_item(OP_REG_WRITE, 16'h7EFC, 8'h04);
		// Writes just outside the window, to unused slots inside it, and an
		// item with the unused op code must all leave the banks alone.
		push_item(OP_REG_WRITE, 16'h7EEF, 8'h55);
		push_item(OP_REG_WRITE, 16'h7F00, 8'h55);
		push_item(OP_REG_WRITE, 16'h7EF7, 8'hFF);
		push_item(OP_REG_WRITE, 16'h7EFF, 8'hFF);
		push_item(OP_UNUSED, 16'h7EF0, 8'h00);
		push_item(OP_CHR_FETCH, 16'h07FF, 8'h00);
		push_item(OP_CHR_FETCH, 16'h1FFF, 8'h00);
		push_item(OP_PRG_FETCH, 16'h8000, 8'h00);
		push_item(OP_PRG_FETCH, 16'hDFFF, 8'h00);
		// Vertical mirroring with the halves swapped, then both cleared
		// again by a value whose upper bits must be dropped.
		push_item(OP_REG_WRITE, 16'h7EF6, 8'h03);
		push_item(OP_CHR_FETCH, 16'h0000, 8'h00);
		push_item(OP_CHR_FETCH, 16'h1C00, 8'h00);
		push_item(OP_REG_WRITE, 16'h7EF6, 8'hFC);
		push_item(OP_CHR_FETCH, 16'hFFFF, 8'h00);
		push_item(OP_PRG_FETCH, 16'h0000, 8'h00);
		wait_until_idle();

		// Random part: the first two settings are the extremes, the rest are
		// drawn, often small so that the clamp masks bite.
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: begin
					lim_prg = 8'hFF;
					lim_chr2k = 8'h7F;
					lim_chr1k = 8'hFF;
				end
				1: begin
					lim_prg = 8'h00;
					lim_chr2k = 8'h00;
					lim_chr1k = 8'h00;
				end
				default: begin
					lim_prg = $urandom_range(0, 1) ? 8'($urandom_range(0, 15))
						: 8'($urandom_range(0, 255));
					lim_chr2k = $urandom_range(0, 1) ? 8'($urandom_range(0, 15))
						: 8'($urandom_range(0, 127));
					lim_chr1k = $urandom_range(0, 1) ? 8'($urandom_range(0, 15))
						: 8'($urandom_range(0, 255));
				end
			endcase
			set_limit(CFG_PRG_BANK_MAX, lim_prg);
			set_limit(CFG_CHR_2K_BANK_MAX, lim_chr2k);
			set_limit(CFG_CHR_1K_BANK_MAX, lim_chr1k);
			// A write past the last register index must have no effect.
			if (phase == 0)
				set_limit(CFG_NONE, 8'h5A);
			@(posedge clk);
			cfg_we <= 1'b0;

			repeat (ITEMS_PER_PHASE)
				pending_items.push_back(random_item());

			// Once in the run, stop the sender halfway through a phase until
			// the pipeline has fully drained, then let it carry on.
			if (phase == 3) begin
				while (pending_items.size() > ITEMS_PER_PHASE / 2)
					@(posedge clk);
				sender_hold <= 1'b1;
				@(posedge clk);
				while (in_valid || expected_mappings.size() != 0)
					@(negedge clk);
				@(posedge clk);
				sender_hold <= 1'b0;
			end
			wait_until_idle();
		end

		repeat (10) @(posedge clk);
		$display("Sent %0d items (%0d register writes) under %0d bank limit settings.",
			items_sent, reg_writes_sent, PHASES + 1);
		$display("Checked %0d results, %0d of them mapped fetches, with random gaps on both sides.",
			results_seen, hits_seen);
		if (error_count == 0) begin
			$display("** bank_mapper_with_chr_layout_swap_unit: PASSED **");
		end else begin
			$display("%0d mismatches found", error_count);
			$display("** bank_mapper_with_chr_layout_swap_unit: FAILED **");
		end
		$finish;
	end

	// Watchdog: the slowest legal run is far below this.
	initial begin
		#5_000_000;
		$display("Run timed out with %0d results outstanding", expected_mappings.size());
		$display("** bank_mapper_with_chr_layout_swap_unit: FAILED **");
		$finish;
	end

endmodule

@@ files.f @@
rtl/bmcls_pkg.sv
rtl/bank_mapper_with_chr_layout_swap_unit.sv
verif/tb.sv
